// ===== hdl/truss_bar_stiffness_2d_defines.svh =====
// assertion macros shared by the block
`ifndef TRUSS_BAR_STIFFNESS_2D_DEFINES_SVH
`define TRUSS_BAR_STIFFNESS_2D_DEFINES_SVH

// same-cycle implication
`define TBS_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("tbs check failed");

// next-cycle implication
`define TBS_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("tbs check failed");

`endif

// ===== hdl/tbs_pkg.sv =====
package tbs_pkg;
	localparam int COORD_W = 32;
	localparam int DIFF_W  = 33;
	localparam int SUM_W   = 66;
	localparam int LEN_W   = 33;
	localparam int K_W     = 63;
	localparam int COS_W   = 33;
	localparam logic [K_W-1:0] MAX63 = {K_W{1'b1}};
endpackage

// ===== hdl/truss_bar_stiffness_2d.sv =====
// 2d truss bar stiffness pipeline
// request channel: req_valid / req_stall with the bar end coordinates
//   (signed fixed point), area and modulus (unsigned fixed point)
// result channel: res_valid / res_stall with axial stiffness k = A*E/L and
//   the global matrix entries k*c*c, k*c*s, k*s*s (unsigned Q31.32, cs signed
//   Q32.32), plus the zero_length and saturated flags
// stages: 3 front stages, 33 square root stages, 63 divider stages, two
//   layers of 2-stage scaling multipliers and the output register
// throughput: one request per cycle unless a result is held under res_stall;
//   the square root and the three dividers retire one result bit per stage,
//   so every stage holds its own request
// a stalled result holds the whole pipeline: req_stall is raised while a
//   result waits under res_stall, nothing is lost or repeated
// reset clears every stage valid bit; data registers are not reset
// a zero-length bar gives all-zero entries with zero_length set
// k above 2^63-1 clips and sets saturated; entries then use the clipped k
module truss_bar_stiffness_2d #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] end_x,
	input  logic signed [31:0] end_y,
	input  logic [31:0] area,
	input  logic [31:0] modulus,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [62:0] axial_stiffness,
	output logic [62:0] stiff_cc,
	output logic signed [63:0] stiff_cs,
	output logic [62:0] stiff_ss,
	output logic        zero_length,
	output logic        saturated
);
	localparam int DW    = tbs_pkg::DIFF_W;
	localparam int SW    = tbs_pkg::SUM_W;
	localparam int LW    = tbs_pkg::LEN_W;
	localparam int KW    = tbs_pkg::K_W;
	localparam int CW    = tbs_pkg::COS_W;
	localparam int SHIFT = 32 - FRAC_BITS;
	localparam int NUM_W = 64 + SHIFT;
	// sideband into the square root: ax, ay, A*E, sign, zero
	localparam int SQ_TW = 2 * DW + 64 + 2;
	// sideband through the first scaling pair: sign, zero, sat, k, cm, sm
	localparam int SA_TW = 3 + KW + 2 * CW;
	localparam int SB_TW = 3 + KW;

	// global advance: the pipeline moves unless a result is held
	logic en;
	assign en        = !(res_valid && res_stall);
	assign req_stall = !en;

	// front stage 1: differences, magnitudes, A*E
	logic signed [DW-1:0] dx, dy;
	logic [DW-1:0] ax_s1, ay_s1;
	logic [63:0]   prod_s1;
	logic          neg_s1, zero_s1, v_s1;

	assign dx = DW'(end_x) - DW'(start_x);
	assign dy = DW'(end_y) - DW'(start_y);

	// front stage 2: squares
	logic [SW-1:0] x2_s2, y2_s2;
	logic [DW-1:0] ax_s2, ay_s2;
	logic [63:0]   prod_s2;
	logic          neg_s2, zero_s2, v_s2;

	// front stage 3: sum of squares
	logic [SW-1:0] sum_s3;
	logic [DW-1:0] ax_s3, ay_s3;
	logic [63:0]   prod_s3;
	logic          neg_s3, zero_s3, v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1   <= dx[DW-1] ? DW'(-dx) : DW'(dx);
			ay_s1   <= dy[DW-1] ? DW'(-dy) : DW'(dy);
			prod_s1 <= area * modulus;
			// cs is negative when exactly one difference is negative
			neg_s1  <= dx[DW-1] ^ dy[DW-1];
			zero_s1 <= (dx == '0) && (dy == '0);

			x2_s2   <= ax_s1 * ax_s1;
			y2_s2   <= ay_s1 * ay_s1;
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			prod_s2 <= prod_s1;
			neg_s2  <= neg_s1;
			zero_s2 <= zero_s1;

			sum_s3  <= x2_s2 + y2_s2;
			ax_s3   <= ax_s2;
			ay_s3   <= ay_s2;
			prod_s3 <= prod_s2;
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
		end
	end

	// length by bit-serial square root
	logic             sq_v;
	logic [LW-1:0]    len;
	logic [SQ_TW-1:0] sq_tag;
	logic [DW-1:0]    ax_q, ay_q;
	logic [63:0]      prod_q;
	logic             neg_q, zero_q;

	tbs_sqrt #(.TW(SQ_TW)) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (v_s3),
		.val     (sum_s3),
		.tag_in  ({ax_s3, ay_s3, prod_s3, neg_s3, zero_s3}),
		.out_v   (sq_v),
		.root    (len),
		.tag_out (sq_tag)
	);

	assign {ax_q, ay_q, prod_q, neg_q, zero_q} = sq_tag;

	// three dividers share the length; zero length divides by one, result masked
	logic [LW-1:0]    den;
	logic [NUM_W-1:0] num_k, num_c, num_s;

	assign den   = (len == '0) ? LW'(1) : len;
	assign num_k = {prod_q, {SHIFT{1'b0}}};
	assign num_c = {{(NUM_W-DW-32){1'b0}}, ax_q, 32'd0};
	assign num_s = {{(NUM_W-DW-32){1'b0}}, ay_q, 32'd0};

	logic          dk_v, k_sat, c_ovf, s_ovf;
	logic [KW-1:0] k_quo, c_quo, s_quo;
	logic [1:0]    dk_tag, dc_tag, ds_tag;
	logic          dc_v, ds_v;

	tbs_div #(.NW(NUM_W), .TW(2)) u_div_k (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(sq_v),
		.num(num_k), .den(den), .tag_in({neg_q, zero_q}),
		.out_v(dk_v), .quo(k_quo), .sat(k_sat), .tag_out(dk_tag)
	);

	tbs_div #(.NW(NUM_W), .TW(2)) u_div_c (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(sq_v),
		.num(num_c), .den(den), .tag_in({neg_q, zero_q}),
		.out_v(dc_v), .quo(c_quo), .sat(c_ovf), .tag_out(dc_tag)
	);

	tbs_div #(.NW(NUM_W), .TW(2)) u_div_s (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(sq_v),
		.num(num_s), .den(den), .tag_in({neg_q, zero_q}),
		.out_v(ds_v), .quo(s_quo), .sat(s_ovf), .tag_out(ds_tag)
	);

	// clip k; cosines never exceed 2^32 so they fit in 33 bits
	logic [KW-1:0] k_clip;
	logic [CW-1:0] cm, sm;

	assign k_clip = k_sat ? tbs_pkg::MAX63 : k_quo;
	assign cm     = c_quo[CW-1:0];
	assign sm     = s_quo[CW-1:0];

	// first scaling pair: t = k*c, u = k*s
	logic             ta_v, ua_v;
	logic [KW-1:0]    t_val, u_val;
	logic [SA_TW-1:0] ta_tag, ua_tag;
	logic             neg_a, zero_a, sat_a;
	logic [KW-1:0]    k_a;
	logic [CW-1:0]    cm_a, sm_a;

	tbs_scale #(.TW(SA_TW)) u_scale_t (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(dk_v),
		.a(k_clip), .c(cm),
		.tag_in({dk_tag, k_sat, k_clip, cm, sm}),
		.out_v(ta_v), .res(t_val), .tag_out(ta_tag)
	);

	tbs_scale #(.TW(SA_TW)) u_scale_u (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(dk_v),
		.a(k_clip), .c(sm),
		.tag_in({dk_tag, k_sat, k_clip, cm, sm}),
		.out_v(ua_v), .res(u_val), .tag_out(ua_tag)
	);

	assign {neg_a, zero_a, sat_a, k_a, cm_a, sm_a} = ua_tag;

	// second scaling trio: cc = t*c, cs = t*s, ss = u*s
	logic             cc_v, cs_v, ss_v;
	logic [KW-1:0]    cc_val, cs_val, ss_val;
	logic [SB_TW-1:0] cc_tag, cs_tag, ss_tag;
	logic             neg_b, zero_b, sat_b;
	logic [KW-1:0]    k_b;

	tbs_scale #(.TW(SB_TW)) u_scale_cc (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(ua_v),
		.a(t_val), .c(cm_a), .tag_in({neg_a, zero_a, sat_a, k_a}),
		.out_v(cc_v), .res(cc_val), .tag_out(cc_tag)
	);

	tbs_scale #(.TW(SB_TW)) u_scale_cs (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(ua_v),
		.a(t_val), .c(sm_a), .tag_in({neg_a, zero_a, sat_a, k_a}),
		.out_v(cs_v), .res(cs_val), .tag_out(cs_tag)
	);

	tbs_scale #(.TW(SB_TW)) u_scale_ss (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(ua_v),
		.a(u_val), .c(sm_a), .tag_in({neg_a, zero_a, sat_a, k_a}),
		.out_v(ss_v), .res(ss_val), .tag_out(ss_tag)
	);

	assign {neg_b, zero_b, sat_b, k_b} = cs_tag;

	// output register: sign of cs, zero-length masking
	logic signed [63:0] cs_signed;
	assign cs_signed = neg_b ? -$signed({1'b0, cs_val}) : $signed({1'b0, cs_val});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (en) begin
			res_valid <= cs_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			axial_stiffness <= zero_b ? '0 : k_b;
			stiff_cc        <= zero_b ? '0 : cc_val;
			stiff_cs        <= zero_b ? '0 : cs_signed;
			stiff_ss        <= zero_b ? '0 : ss_val;
			zero_length     <= zero_b;
			saturated       <= sat_b && !zero_b;
		end
	end

`include "truss_bar_stiffness_2d_defines.svh"

	`TBS_ASSERT_NOW(a_zero_clean, res_valid && zero_length,
		axial_stiffness == '0 && stiff_cs == '0 && !saturated)
	`TBS_ASSERT_NOW(a_sat_max, res_valid && saturated, axial_stiffness == tbs_pkg::MAX63)
	`TBS_ASSERT_NOW(a_entries_bound, res_valid,
		stiff_cc <= axial_stiffness && stiff_ss <= axial_stiffness)
	`TBS_ASSERT_NOW(a_hold_back, res_valid && res_stall, req_stall)
	`TBS_ASSERT_NOW(a_lane_align, dk_v || ua_v || cs_v,
		dc_v == dk_v && ds_v == dk_v && ta_v == ua_v && cc_v == cs_v && ss_v == cs_v
		&& (!dk_v || (dc_tag == dk_tag && ds_tag == dk_tag && !c_ovf && !s_ovf))
		&& (!ua_v || ta_tag == ua_tag)
		&& (!cs_v || (cc_tag == cs_tag && ss_tag == cs_tag)))
endmodule

// ===== hdl/tbs_sqrt.sv =====
module tbs_sqrt #(
	parameter int TW = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_v,
	input  logic [tbs_pkg::SUM_W-1:0]    val,
	input  logic [TW-1:0]                tag_in,
	output logic                         out_v,
	output logic [tbs_pkg::LEN_W-1:0]    root,
	output logic [TW-1:0]                tag_out
);
	localparam int N  = tbs_pkg::LEN_W;
	localparam int VW = tbs_pkg::SUM_W;
	localparam int RW = N + 2;

	logic [RW-1:0] rem_s  [N];
	logic [N-1:0]  root_s [N];
	logic [VW-1:0] val_s  [N];
	logic [TW-1:0] tag_s  [N];
	logic          v_s    [N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [RW-1:0] rem_p;
		logic [N-1:0]  root_p;
		logic [VW-1:0] val_p;
		logic [TW-1:0] tag_p;
		logic          v_p;
		logic [RW+1:0] trial;
		logic [RW+1:0] sub;
		logic          ge;

		if (i == 0) begin : g_first
			assign rem_p  = '0;
			assign root_p = '0;
			assign val_p  = val;
			assign tag_p  = tag_in;
			assign v_p    = in_v;
		end else begin : g_next
			assign rem_p  = rem_s[i-1];
			assign root_p = root_s[i-1];
			assign val_p  = val_s[i-1];
			assign tag_p  = tag_s[i-1];
			assign v_p    = v_s[i-1];
		end

		assign trial = {rem_p, val_p[VW-1 -: 2]};
		assign sub   = {1'b0, root_p, 2'b01};
		assign ge    = trial >= sub;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? RW'(trial - sub) : RW'(trial);
				root_s[i] <= {root_p[N-2:0], ge};
				val_s[i]  <= {val_p[VW-3:0], 2'b00};
				tag_s[i]  <= tag_p;
			end
		end
	end

	assign out_v   = v_s[N-1];
	assign root    = root_s[N-1];
	assign tag_out = tag_s[N-1];
endmodule

// ===== hdl/tbs_div.sv =====
module tbs_div #(
	parameter int NW = 80,
	parameter int TW = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_v,
	input  logic [NW-1:0]              num,
	input  logic [tbs_pkg::LEN_W-1:0]  den,
	input  logic [TW-1:0]              tag_in,
	output logic                       out_v,
	output logic [tbs_pkg::K_W-1:0]    quo,
	output logic                       sat,
	output logic [TW-1:0]              tag_out
);
	localparam int QW = tbs_pkg::K_W;
	localparam int DW = tbs_pkg::LEN_W;
	localparam int HW = NW - QW;

	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] nb_s  [QW];
	logic [QW-1:0] q_s   [QW];
	logic [DW-1:0] den_s [QW];
	logic          sat_s [QW];
	logic [TW-1:0] tag_s [QW];
	logic          v_s   [QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [DW-1:0] rem_p;
		logic [QW-1:0] nb_p;
		logic [QW-1:0] q_p;
		logic [DW-1:0] den_p;
		logic          sat_p;
		logic [TW-1:0] tag_p;
		logic          v_p;
		logic [DW:0]   trial;
		logic          ge;

		if (i == 0) begin : g_first
			// top bits already at or above the divisor mean the quotient overflows
			assign rem_p = {{(DW-HW){1'b0}}, num[NW-1:QW]};
			assign nb_p  = num[QW-1:0];
			assign q_p   = '0;
			assign den_p = den;
			assign sat_p = rem_p >= den;
			assign tag_p = tag_in;
			assign v_p   = in_v;
		end else begin : g_next
			assign rem_p = rem_s[i-1];
			assign nb_p  = nb_s[i-1];
			assign q_p   = q_s[i-1];
			assign den_p = den_s[i-1];
			assign sat_p = sat_s[i-1];
			assign tag_p = tag_s[i-1];
			assign v_p   = v_s[i-1];
		end

		assign trial = {rem_p, nb_p[QW-1]};
		assign ge    = trial >= {1'b0, den_p};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? DW'(trial - {1'b0, den_p}) : DW'(trial);
				nb_s[i]  <= {nb_p[QW-2:0], 1'b0};
				q_s[i]   <= {q_p[QW-2:0], ge};
				den_s[i] <= den_p;
				sat_s[i] <= sat_p;
				tag_s[i] <= tag_p;
			end
		end
	end

	assign out_v   = v_s[QW-1];
	assign quo     = q_s[QW-1];
	assign sat     = sat_s[QW-1];
	assign tag_out = tag_s[QW-1];
endmodule

// ===== hdl/tbs_scale.sv =====
module tbs_scale #(
	parameter int TW = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_v,
	input  logic [tbs_pkg::K_W-1:0]    a,
	input  logic [tbs_pkg::COS_W-1:0]  c,
	input  logic [TW-1:0]              tag_in,
	output logic                       out_v,
	output logic [tbs_pkg::K_W-1:0]    res,
	output logic [TW-1:0]              tag_out
);
	localparam int KW = tbs_pkg::K_W;
	localparam int CW = tbs_pkg::COS_W;

	// floor(a * c / 2^32) from two partial products
	logic [KW-32+CW-1:0] hi_s1;
	logic [32+CW-1:0]    lo_s1;
	logic [TW-1:0]       tag_s1;
	logic                v_s1;
	logic [KW-1:0]       res_s2;
	logic [TW-1:0]       tag_s2;
	logic                v_s2;
	logic [KW-32+CW:0]   sum;

	assign sum = {1'b0, hi_s1} + (KW-32+CW+1)'(lo_s1[32+CW-1:32]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hi_s1  <= a[KW-1:32] * c;
			lo_s1  <= a[31:0] * c;
			tag_s1 <= tag_in;
			res_s2 <= sum[KW-1:0];
			tag_s2 <= tag_s1;
		end
	end

	assign out_v   = v_s2;
	assign res     = res_s2;
	assign tag_out = tag_s2;
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

// bench for the 2d truss bar stiffness pipeline
module tb;
	localparam int FRAC = 16;
	localparam int TAIL_CYCLES = 160;      // pipeline is 104 deep, leave margin
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_BARS = 450;

	// one bar request
	typedef struct {
		logic signed [31:0] sx, sy, ex, ey;
		logic [31:0] ar, md;
	} bar_t;

	// one result
	typedef struct {
		logic [62:0] k, cc, ss;
		logic signed [63:0] cs;
		logic zl, sat;
	} stiff_t;

	// directed row: bar plus an optional typed-in result
	typedef struct {
		bar_t bar;
		bit known;
		stiff_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic signed [31:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
	logic [31:0] area = '0, modulus = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [62:0] axial_stiffness, stiff_cc, stiff_ss;
	logic signed [63:0] stiff_cs;
	logic zero_length, saturated;

	stiff_t pending_entries[$];
	int mismatches = 0;
	int cycles = 0;
	bit calm = 1'b0;          // when set, neither side idles
	int hold_left = 0;

	always #4 clk = ~clk;

	truss_bar_stiffness_2d #(.FRAC_BITS(FRAC)) dut (.*);

	// bit-exact prediction of one bar
	function automatic stiff_t bar_stiffness(bar_t b);
		logic signed [32:0] dx, dy;
		logic [32:0] ax, ay;
		logic [127:0] sq, len, trial, cm, sm, num, kq, kk, t, t2;
		logic [63:0] cs;
		stiff_t r;
		r = '{default: '0};
		dx = {b.ex[31], b.ex} - {b.sx[31], b.sx};
		dy = {b.ey[31], b.ey} - {b.sy[31], b.sy};
		ax = dx[32] ? -dx : dx;
		ay = dy[32] ? -dy : dy;
		// coincident nodes: everything zero, flag set
		if (ax == 0 && ay == 0) begin
			r.zl = 1'b1;
			return r;
		end
		sq = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
		len = '0;
		for (int i = 32; i >= 0; i--) begin
			trial = len | (128'd1 << i);
			if (trial * trial <= sq)
				len = trial;
		end
		cm = (128'(ax) << 32) / len;
		sm = (128'(ay) << 32) / len;
		num = (128'(b.ar) * 128'(b.md)) << (32 - FRAC);
		kq = num / len;
		// clip k, entries then come from the clipped value
		if (kq > 128'(tbs_pkg::MAX63)) begin
			kk = 128'(tbs_pkg::MAX63);
			r.sat = 1'b1;
		end else begin
			kk = kq;
		end
		t = (kk * cm) >> 32;
		t2 = (kk * sm) >> 32;
		r.k = kk[62:0];
		r.cc = 63'((t * cm) >> 32);
		cs = 64'((t * sm) >> 32);
		r.ss = 63'((t2 * sm) >> 32);
		if (dx[32] != dy[32])
			cs = -cs;
		r.cs = cs;
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
		mismatches++;
	endtask

	// send one request, idling a random number of cycles first unless calm is set
	task automatic send_bar(bar_t b, bit known, stiff_t res);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		start_x <= b.sx;
		start_y <= b.sy;
		end_x <= b.ex;
		end_y <= b.ey;
		area <= b.ar;
		modulus <= b.md;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		// accepted at this edge
		pending_entries.push_back(known ? res : bar_stiffness(b));
	endtask

	// random bar: half are corner shapes, the rest small mesh-sized or fully random
	function automatic bar_t random_bar();
		bar_t b;
		int kind;
		b.sx = $urandom; b.sy = $urandom; b.ex = $urandom; b.ey = $urandom;
		b.ar = $urandom; b.md = $urandom;
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1: begin
				// small mesh-sized coordinates and properties
				b.sx = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
				b.sy = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
				b.ex = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
				b.ey = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
				b.ar = $urandom_range(0, 32'h0004_0000);
				b.md = $urandom_range(0, 32'h0100_0000);
			end
			2: begin
				// coincident nodes
				b.ex = b.sx;
				b.ey = b.sy;
			end
			3: b.ey = b.sy;                    // horizontal bar
			4: b.ex = b.sx;                    // vertical bar
			5: begin
				// very short bar, overflow likely
				b.ex = b.sx + $signed($urandom_range(0, 6)) - 3;
				b.ey = b.sy + $signed($urandom_range(0, 6)) - 3;
			end
			6: if ($urandom_range(0, 1)) b.ar = '0; else b.md = '0;
			default: ;
		endcase
		return b;
	endfunction

	// result side: random stall after each taken result
	always @(posedge clk or negedge arst_n) begin
		stiff_t w;
		int idle;
		if (!arst_n) begin
			res_stall <= 1'b0;
			hold_left <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (pending_entries.size() == 0) begin
					report("extra result", 64'(axial_stiffness), 64'(0));
				end else begin
					w = pending_entries.pop_front();
					if (axial_stiffness !== w.k) report("axial_stiffness", 64'(axial_stiffness), 64'(w.k));
					if (stiff_cc !== w.cc) report("stiff_cc", 64'(stiff_cc), 64'(w.cc));
					if (stiff_cs !== w.cs) report("stiff_cs", stiff_cs, w.cs);
					if (stiff_ss !== w.ss) report("stiff_ss", 64'(stiff_ss), 64'(w.ss));
					if (zero_length !== w.zl) report("zero_length", 64'(zero_length), 64'(w.zl));
					if (saturated !== w.sat) report("saturated", 64'(saturated), 64'(w.sat));
				end
				idle = calm ? 0 : $urandom_range(0, 3);
				hold_left <= idle;
				res_stall <= (idle > 0);
			end else if (hold_left > 1) begin
				hold_left <= hold_left - 1;
			end else if (hold_left == 1) begin
				hold_left <= 0;
				res_stall <= 1'b0;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		row_t rows[$];
		row_t r;
		stiff_t zeros, zl_res, sat_x, sat_y;
		bar_t b;

		zeros = '{default: '0};
		zl_res = zeros; zl_res.zl = 1'b1;
		// one-lsb bar with full area and modulus: k clips, all in one direction
		sat_x = zeros; sat_x.k = tbs_pkg::MAX63; sat_x.cc = tbs_pkg::MAX63; sat_x.sat = 1'b1;
		sat_y = zeros; sat_y.k = tbs_pkg::MAX63; sat_y.ss = tbs_pkg::MAX63; sat_y.sat = 1'b1;

		// coincident nodes
		r.bar = '{32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000, 32'sh0002_0000, '1, '1};
		r.known = 1; r.res = zl_res; rows.push_back(r);
		r.bar = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, '0, '0};
		r.known = 1; r.res = zl_res; rows.push_back(r);
		// zero area, zero modulus
		r.bar = '{0, 0, 32'sh0003_0000, 32'sh0004_0000, '0, 32'h1234_5678};
		r.known = 1; r.res = zeros; rows.push_back(r);
		r.bar = '{0, 0, 32'sh0003_0000, 32'sh0004_0000, 32'h0001_0000, '0};
		r.known = 1; r.res = zeros; rows.push_back(r);
		// stiffness overflow on minimal bars
		r.bar = '{0, 0, 1, 0, '1, '1};
		r.known = 1; r.res = sat_x; rows.push_back(r);
		r.bar = '{5, 9, 5, 10, '1, '1};
		r.known = 1; r.res = sat_y; rows.push_back(r);
		r.bar = '{7, 7, 6, 7, '1, '1};
		r.known = 1; r.res = sat_x; rows.push_back(r);
		// predicted rows: 3-4-5 bar in each quadrant, extremes
		r.known = 0; r.res = zeros;
		r.bar = '{0, 0, 32'sh0003_0000, 32'sh0004_0000, 32'h0001_0000, 32'h0001_0000};
		rows.push_back(r);
		r.bar = '{0, 0, -32'sh0003_0000, 32'sh0004_0000, 32'h0002_0000, 32'h0010_0000};
		rows.push_back(r);
		r.bar = '{0, 0, 32'sh0003_0000, -32'sh0004_0000, 32'h0002_0000, 32'h0010_0000};
		rows.push_back(r);
		r.bar = '{0, 0, -32'sh0003_0000, -32'sh0004_0000, 32'h0002_0000, 32'h0010_0000};
		rows.push_back(r);
		r.bar = '{32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, '1, '1};
		rows.push_back(r);
		r.bar = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 1, 1};
		rows.push_back(r);
		r.bar = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, '1, 1};
		rows.push_back(r);
		r.bar = '{32'sh8000_0000, 0, 32'sh7fff_ffff, 0, 1, '1};
		rows.push_back(r);
		r.bar = '{0, 32'sh8000_0000, 0, 32'sh7fff_ffff, 32'h8000_0000, 32'h8000_0000};
		rows.push_back(r);
		r.bar = '{1, 1, 2, 2, 32'h0000_0001, 32'h0000_0001};
		rows.push_back(r);
		r.bar = '{0, 0, 32'sh0001_0000, 0, 32'hffff_ffff, 32'h0000_ffff};
		rows.push_back(r);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_bar(rows[i].bar, rows[i].known, rows[i].res);

		for (int n = 0; n < RANDOM_BARS; n++) begin
			// a stretch in the middle runs without any idling
			calm = (n >= 200 && n < 260);
			b = random_bar();
			send_bar(b, 1'b0, zeros);
		end
		calm = 1'b0;
		req_valid <= 1'b0;

		while (pending_entries.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/tbs_pkg.sv
hdl/tbs_sqrt.sv
hdl/tbs_div.sv
hdl/tbs_scale.sv
hdl/truss_bar_stiffness_2d.sv
bench/tb.sv
